### rtl/scc_pkg.sv
// Shared widths, types and constants for the spectral current correction block.
package scc_pkg;

   localparam int unsigned DATA_W       = 32;   // width of every current, density and wavenumber
   localparam int unsigned CSR_W        = 31;   // width of the reciprocal time step register
   localparam int unsigned DVD_W        = 97;   // |k| * |N| dividend width
   localparam int unsigned DSR_W        = 65;   // k2 or 2*k2 divisor width
   localparam int unsigned QBITS        = 63;   // quotient bits resolved by the divider
   localparam int unsigned INC_W        = 64;   // signed increment width
   localparam int unsigned FRONT_STAGES = 7;    // stages before the divider
   localparam int unsigned DIV_STAGES   = QBITS + 1;
   localparam int unsigned ALIGN        = FRONT_STAGES + DIV_STAGES;
   localparam int unsigned PIPE_LEN     = ALIGN + 1;
   localparam logic [CSR_W-1:0] INV_DT_RESET = CSR_W'(65536);
   localparam logic [QBITS-1:0] INC_LIMIT    = QBITS'(64'h4000_0000_0000_0000);

   // Currents and the correction flag carried alongside the arithmetic.
   typedef struct packed {
      logic signed [DATA_W-1:0] jp_re;
      logic signed [DATA_W-1:0] jp_im;
      logic signed [DATA_W-1:0] jm_re;
      logic signed [DATA_W-1:0] jm_im;
      logic signed [DATA_W-1:0] jz_re;
      logic signed [DATA_W-1:0] jz_im;
      logic                     corr;
   } side_type;

endpackage

### rtl/scc_div.sv
// Pipelined restoring divider giving a clamped, signed, truncated quotient.
module scc_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic [scc_pkg::DVD_W-1:0]         dvd_in,
   input  logic [scc_pkg::DSR_W-1:0]         dsr_in,
   input  logic                              neg_in,
   output logic signed [scc_pkg::INC_W-1:0]  quo_out
);
   import scc_pkg::*;

   logic [DSR_W-1:0] rem_ff [QBITS];
   logic [QBITS-1:0] low_ff [QBITS];
   logic [QBITS-1:0] q_ff   [QBITS];
   logic [DSR_W-1:0] d_ff   [QBITS];
   logic             neg_ff [QBITS];
   logic             ovf_ff [QBITS];

   logic [DSR_W-1:0] rem_in [QBITS];
   logic [QBITS-1:0] low_in [QBITS];
   logic [QBITS-1:0] q_in   [QBITS];

   logic [DSR_W-1:0] src_rem [QBITS];
   logic [QBITS-1:0] src_low [QBITS];
   logic [QBITS-1:0] src_q   [QBITS];
   logic [DSR_W-1:0] src_d   [QBITS];
   logic [DSR_W:0]   trial   [QBITS];
   logic             ge      [QBITS];

   logic                    ovf_in;
   logic [QBITS-1:0]        mag;
   logic signed [INC_W-1:0] quo_ff;
   logic signed [INC_W-1:0] quo_in;

   // A quotient of 2^63 or more is flagged before the first step.
   assign ovf_in = DSR_W'(dvd_in[DVD_W-1:QBITS]) >= dsr_in;

   always_comb begin
      for (int j = 0; j < QBITS; j++) begin
         if (j == 0) begin
            src_rem[j] = DSR_W'(dvd_in[DVD_W-1:QBITS]);
            src_low[j] = dvd_in[QBITS-1:0];
            src_q[j]   = '0;
            src_d[j]   = dsr_in;
         end else begin
            src_rem[j] = rem_ff[j-1];
            src_low[j] = low_ff[j-1];
            src_q[j]   = q_ff[j-1];
            src_d[j]   = d_ff[j-1];
         end
         trial[j]  = {src_rem[j], src_low[j][QBITS-1]};
         ge[j]     = trial[j] >= {1'b0, src_d[j]};
         rem_in[j] = ge[j] ? DSR_W'(trial[j] - {1'b0, src_d[j]}) : trial[j][DSR_W-1:0];
         low_in[j] = {src_low[j][QBITS-2:0], 1'b0};
         q_in[j]   = {src_q[j][QBITS-2:0], ge[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < QBITS; j++) begin
            rem_ff[j] <= rem_in[j];
            low_ff[j] <= low_in[j];
            q_ff[j]   <= q_in[j];
            d_ff[j]   <= src_d[j];
         end
         neg_ff[0] <= neg_in;
         ovf_ff[0] <= ovf_in;
         for (int j = 1; j < QBITS; j++) begin
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   always_comb begin
      mag = (ovf_ff[QBITS-1] || (q_ff[QBITS-1] > INC_LIMIT)) ? INC_LIMIT : q_ff[QBITS-1];
      quo_in = neg_ff[QBITS-1] ? -$signed(INC_W'(mag)) : $signed(INC_W'(mag));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo_out = quo_ff;

endmodule

### rtl/spectral_current_correction_top.sv
// Top level of the spectral current correction pipeline.
//
//  Channel | Direction | Payload
//  --------+-----------+-----------------------------------------------------
//  req_    | in        | tdata: jp, jm, jz, rho_old, rho_new (re, im), kr, kz
//  rsp_    | out       | tdata: corrected jp, jm, jz; tuser: flags
//  csr_    | in        | data: inv_dt, reciprocal time step
//
// One transaction is accepted per cycle while req_tready is high; each result is registered
// through the front stages, the divider and the sum stage before the output register.
// Most of the pipeline is the 63-step restoring divide, one quotient bit per stage.
// Reset empties the pipeline and restores inv_dt to 1.0; the csr channel is always ready.
// A stalled result holds every stage, but a bubble just ahead of the output register
// still lets the pipeline move, so new requests are taken while the result waits.
module spectral_current_correction_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // jp_re, jp_im, jm_re, jm_im, jz_re, jz_im, rho_old_re, rho_old_im,
   // rho_new_re, rho_new_im, radial_wavenumber, axial_wavenumber (32 bits each)
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // jp_re_out, jp_im_out, jm_re_out, jm_im_out, jz_re_out, jz_im_out (32 bits each)
   output logic [191:0] rsp_tdata,
   // was_corrected, saturated
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [scc_pkg::CSR_W-1:0] csr_data
);
   import scc_pkg::*;

   localparam int unsigned W = DATA_W;

   // Saturate a wide signed sum to the output range; bit W is the clip flag.
   function automatic logic [W:0] clip(input logic signed [INC_W:0] v);
      logic [W:0] r;
      if (v > $signed((INC_W+1)'({1'b0, {(W-1){1'b1}}}))) begin
         r = {1'b1, 1'b0, {(W-1){1'b1}}};
      end else if (v < -$signed((INC_W+1)'({1'b1, {(W-1){1'b0}}}))) begin
         r = {1'b1, 1'b1, {(W-1){1'b0}}};
      end else begin
         r = {1'b0, v[W-1:0]};
      end
      return r;
   endfunction

   // Configuration register.
   logic [CSR_W-1:0] inv_dt_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_dt_ff <= INV_DT_RESET;
      end else if (csr_valid) begin
         inv_dt_ff <= csr_data;
      end
   end

   // Flow control: the output register loads when empty or taken, and the pipeline moves
   // when the output loads or when the sum stage holds a bubble.
   logic rsp_tvalid_ff;
   logic out_load;
   logic adv;
   logic vld_ff [PIPE_LEN];

   assign out_load   = !rsp_tvalid_ff || rsp_tready;
   assign adv        = out_load || !vld_ff[PIPE_LEN-1];
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LEN; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < PIPE_LEN; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Stage 1: request registers and the side line that carries the currents.
   logic signed [W-1:0] f_ff [12];
   side_type side_in;
   side_type side_ff [ALIGN];

   always_comb begin
      side_in.jp_re = $signed(req_tdata[0*W +: W]);
      side_in.jp_im = $signed(req_tdata[1*W +: W]);
      side_in.jm_re = $signed(req_tdata[2*W +: W]);
      side_in.jm_im = $signed(req_tdata[3*W +: W]);
      side_in.jz_re = $signed(req_tdata[4*W +: W]);
      side_in.jz_im = $signed(req_tdata[5*W +: W]);
      // k2 is zero exactly when both wavenumbers are zero.
      side_in.corr  = (req_tdata[10*W +: W] != '0) || (req_tdata[11*W +: W] != '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 12; i++) begin
            f_ff[i] <= $signed(req_tdata[i*W +: W]);
         end
         side_ff[0] <= side_in;
         for (int i = 1; i < ALIGN; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Stage 2: differences of densities and of the transverse currents.
   logic signed [W:0]   drho_re_ff, drho_im_ff, djp_re_ff, djp_im_ff;
   logic signed [W-1:0] kr2_ff, kz2_ff, jzr2_ff, jzi2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         drho_re_ff <= (W+1)'(f_ff[8]) - (W+1)'(f_ff[6]);
         drho_im_ff <= (W+1)'(f_ff[9]) - (W+1)'(f_ff[7]);
         djp_re_ff  <= (W+1)'(f_ff[0]) - (W+1)'(f_ff[2]);
         djp_im_ff  <= (W+1)'(f_ff[1]) - (W+1)'(f_ff[3]);
         kr2_ff     <= f_ff[10];
         kz2_ff     <= f_ff[11];
         jzr2_ff    <= f_ff[4];
         jzi2_ff    <= f_ff[5];
      end
   end

   // Stage 3: the products that make up N and k2.
   logic signed [2*W-1:0] prho_re_ff, prho_im_ff, kzjz_re_ff, kzjz_im_ff;
   logic signed [2*W-1:0] krjp_re_ff, krjp_im_ff;
   logic [2*W-2:0]        krsq_ff, kzsq_ff;
   logic signed [W-1:0]   kr3_ff, kz3_ff;
   logic signed [W:0]     idt_s;
   logic signed [2*W+1:0] prho_re_w, prho_im_w, krjp_re_w, krjp_im_w;
   logic signed [2*W-1:0] krsq_w, kzsq_w;

   assign idt_s = $signed((W+1)'(inv_dt_ff));
   always_comb begin
      prho_re_w = (2*W+2)'(drho_re_ff) * (2*W+2)'(idt_s);
      prho_im_w = (2*W+2)'(drho_im_ff) * (2*W+2)'(idt_s);
      krjp_re_w = (2*W+2)'(kr2_ff) * (2*W+2)'(djp_re_ff);
      krjp_im_w = (2*W+2)'(kr2_ff) * (2*W+2)'(djp_im_ff);
      krsq_w    = (2*W)'(kr2_ff) * (2*W)'(kr2_ff);
      kzsq_w    = (2*W)'(kz2_ff) * (2*W)'(kz2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prho_re_ff <= prho_re_w[2*W-1:0];
         prho_im_ff <= prho_im_w[2*W-1:0];
         kzjz_re_ff <= (2*W)'(kz2_ff) * (2*W)'(jzr2_ff);
         kzjz_im_ff <= (2*W)'(kz2_ff) * (2*W)'(jzi2_ff);
         krjp_re_ff <= krjp_re_w[2*W-1:0];
         krjp_im_ff <= krjp_im_w[2*W-1:0];
         krsq_ff    <= krsq_w[2*W-2:0];
         kzsq_ff    <= kzsq_w[2*W-2:0];
         kr3_ff     <= kr2_ff;
         kz3_ff     <= kz2_ff;
      end
   end

   // Stage 4: N = (rho_new - rho_old)*inv_dt + i*kz*Jz + kr*(Jp - Jm), and k2.
   logic signed [2*W+1:0] n_re_ff, n_im_ff;
   logic [2*W-1:0]        k2_ff;
   logic signed [W-1:0]   kr4_ff, kz4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         n_re_ff <= (2*W+2)'(prho_re_ff) - (2*W+2)'(kzjz_im_ff) + (2*W+2)'(krjp_re_ff);
         n_im_ff <= (2*W+2)'(prho_im_ff) + (2*W+2)'(kzjz_re_ff) + (2*W+2)'(krjp_im_ff);
         k2_ff   <= (2*W)'(krsq_ff) + (2*W)'(kzsq_ff);
         kr4_ff  <= kr3_ff;
         kz4_ff  <= kz3_ff;
      end
   end

   // Stage 5: magnitudes and result signs. The increments are -kr*N/(2k2) for Jp,
   // -kz*N_im/k2 for Re Jz and kz*N_re/k2 for Im Jz.
   logic [DSR_W-1:0]    nre_mag_ff, nim_mag_ff;
   logic [W-1:0]        kr_mag_ff, kz_mag_ff;
   logic [3:0]          neg5_ff;
   logic [2*W-1:0]      k2_5_ff;
   logic [2*W+1:0]      nre_abs, nim_abs;
   logic [W-1:0]        kr_abs, kz_abs;

   always_comb begin
      nre_abs = n_re_ff[2*W+1] ? (2*W+2)'(-n_re_ff) : n_re_ff;
      nim_abs = n_im_ff[2*W+1] ? (2*W+2)'(-n_im_ff) : n_im_ff;
      kr_abs  = kr4_ff[W-1] ? W'(-kr4_ff) : kr4_ff;
      kz_abs  = kz4_ff[W-1] ? W'(-kz4_ff) : kz4_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nre_mag_ff <= nre_abs[DSR_W-1:0];
         nim_mag_ff <= nim_abs[DSR_W-1:0];
         kr_mag_ff  <= kr_abs;
         kz_mag_ff  <= kz_abs;
         neg5_ff[0] <= (kr4_ff > 0) != n_re_ff[2*W+1];
         neg5_ff[1] <= (kr4_ff > 0) != n_im_ff[2*W+1];
         neg5_ff[2] <= (kz4_ff > 0) != n_im_ff[2*W+1];
         neg5_ff[3] <= (kz4_ff < 0) != n_re_ff[2*W+1];
         k2_5_ff    <= k2_ff;
      end
   end

   // Stage 6: partial products of |k| and |N|, split at bit 33.
   localparam int unsigned SPLIT = 33;
   logic [W+SPLIT-1:0] plo_ff [4];
   logic [2*W-1:0]     phi_ff [4];
   logic [3:0]         neg6_ff;
   logic [2*W-1:0]     k2_6_ff;
   logic [W-1:0]       mul_a [4];
   logic [DSR_W-1:0]   mul_b [4];

   always_comb begin
      mul_a[0] = kr_mag_ff;  mul_b[0] = nre_mag_ff;
      mul_a[1] = kr_mag_ff;  mul_b[1] = nim_mag_ff;
      mul_a[2] = kz_mag_ff;  mul_b[2] = nim_mag_ff;
      mul_a[3] = kz_mag_ff;  mul_b[3] = nre_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            plo_ff[i] <= (W+SPLIT)'(mul_a[i]) * (W+SPLIT)'(mul_b[i][SPLIT-1:0]);
            phi_ff[i] <= (2*W)'(mul_a[i]) * (2*W)'(mul_b[i][DSR_W-1:SPLIT]);
         end
         neg6_ff <= neg5_ff;
         k2_6_ff <= k2_5_ff;
      end
   end

   // Stage 7: full dividends and divisors.
   logic [DVD_W-1:0] dvd_ff [4];
   logic [DSR_W-1:0] dsr_ff [4];
   logic [3:0]       neg7_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            dvd_ff[i] <= (DVD_W'(phi_ff[i]) << SPLIT) + DVD_W'(plo_ff[i]);
         end
         dsr_ff[0] <= {k2_6_ff, 1'b0};
         dsr_ff[1] <= {k2_6_ff, 1'b0};
         dsr_ff[2] <= DSR_W'(k2_6_ff);
         dsr_ff[3] <= DSR_W'(k2_6_ff);
         neg7_ff   <= neg6_ff;
      end
   end

   // Four divide pipelines: Jp real, Jp imaginary, Jz real, Jz imaginary.
   logic signed [INC_W-1:0] inc [4];
   for (genvar g = 0; g < 4; g++) begin : g_div
      scc_div u_div (
         .clock   (clock),
         .en      (adv),
         .dvd_in  (dvd_ff[g]),
         .dsr_in  (dsr_ff[g]),
         .neg_in  (neg7_ff[g]),
         .quo_out (inc[g])
      );
   end

   // Sum stage: apply the increments, or nothing where k2 is zero.
   side_type                sd;
   logic signed [INC_W-1:0] dp_re, dp_im, dz_re, dz_im;
   logic signed [INC_W:0]   sum_ff [6];
   logic                    corr_ff;

   always_comb begin
      sd    = side_ff[ALIGN-1];
      dp_re = sd.corr ? inc[0] : '0;
      dp_im = sd.corr ? inc[1] : '0;
      dz_re = sd.corr ? inc[2] : '0;
      dz_im = sd.corr ? inc[3] : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff[0] <= (INC_W+1)'(sd.jp_re) + (INC_W+1)'(dp_re);
         sum_ff[1] <= (INC_W+1)'(sd.jp_im) + (INC_W+1)'(dp_im);
         sum_ff[2] <= (INC_W+1)'(sd.jm_re) - (INC_W+1)'(dp_re);
         sum_ff[3] <= (INC_W+1)'(sd.jm_im) - (INC_W+1)'(dp_im);
         sum_ff[4] <= (INC_W+1)'(sd.jz_re) + (INC_W+1)'(dz_re);
         sum_ff[5] <= (INC_W+1)'(sd.jz_im) + (INC_W+1)'(dz_im);
         corr_ff   <= sd.corr;
      end
   end

   // Output register: saturation and flags.
   logic [W:0]   clipped [6];
   logic [191:0] rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]   rsp_tuser_ff, rsp_tuser_in;
   logic         any_sat;

   always_comb begin
      any_sat = 1'b0;
      for (int i = 0; i < 6; i++) begin
         clipped[i] = clip(sum_ff[i]);
         rsp_tdata_in[i*W +: W] = clipped[i][W-1:0];
         any_sat = any_sat | clipped[i][W];
      end
      rsp_tuser_in = {any_sat, corr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= vld_ff[PIPE_LEN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // A pass-through result carries 32-bit currents and can never clip.
   a_pass_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("pass-through result flagged as saturated");

   // With a full sum stage and a stalled output, no request may enter.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PIPE_LEN-1] && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while the pipeline is blocked");

   // A new result only appears from a valid sum stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(vld_ff[PIPE_LEN-1]))
      else $error("result raised without a valid sum stage");

endmodule
